/* rtl/core/ess_pkg.sv */
// shared constants, register indexes and control types for the seeded moving average
package ess_pkg;

  // field and state widths
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 16;
  localparam int SUM_W    = 48;
  localparam int ALPHA_W  = 17;

  // configuration port
  localparam int CFG_W = 17;
  localparam int IDX_W = 1;
  localparam logic [IDX_W-1:0] REG_WINDOW = 1'b0;
  localparam logic [IDX_W-1:0] REG_ALPHA  = 1'b1;

  // fixed values
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [15:0]        WINDOW_INIT = 16'd1;

  // shared datapath sizing
  localparam int DIFF_W    = SAMPLE_W + 1;          // x - prev
  localparam int HI_W      = DIFF_W + 1;            // product high half
  localparam int ACC_W     = HI_W + ALPHA_W;        // full product / dividend
  localparam int MUL_STEPS = ALPHA_W;
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int FRAC_W    = 16;

  // command from the sequencer to the arithmetic unit
  typedef struct packed {
    logic start;
    logic seed;   // 1: rounded mean of the running sum, 0: ema update
  } ess_cmd_t;

  // status from the arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } ess_stat_t;

endpackage

/* rtl/core/ess_unit.sv */
// iterative arithmetic unit: one shared adder does the ema multiply and the seed divide
module ess_unit import ess_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  ess_cmd_t                   cmd,
  output ess_stat_t                  stat,
  input  logic signed [SAMPLE_W-1:0] x,
  input  logic signed [SAMPLE_W-1:0] prev,
  input  logic        [ALPHA_W-1:0]  alpha,
  input  logic signed [SUM_W-1:0]    sum_in,
  input  logic        [15:0]         divisor,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam logic [3:0] U_IDLE = 4'd0;
  localparam logic [3:0] U_DIFF = 4'd1;
  localparam logic [3:0] U_MUL  = 4'd2;
  localparam logic [3:0] U_RND  = 4'd3;
  localparam logic [3:0] U_ADDP = 4'd4;
  localparam logic [3:0] U_ABS  = 4'd5;
  localparam logic [3:0] U_DIV  = 4'd6;
  localparam logic [3:0] U_RCMP = 4'd7;
  localparam logic [3:0] U_RINC = 4'd8;
  localparam logic [3:0] U_SIGN = 4'd9;

  logic [3:0]        phase;
  logic [STEP_W-1:0] step;
  logic [ACC_W-1:0]  acc;     // {hi, multiplier} or {0, quotient}
  logic [DIFF_W-1:0] dval;
  logic [15:0]       rem;
  logic              neg;
  logic              rnd;
  logic              done;

  logic [ACC_W-1:0] opa;
  logic [ACC_W-1:0] opb;
  logic             sub;
  logic [ACC_W-1:0] sum_w;
  logic [16:0]      rem_shift;
  logic [HI_W-1:0]  hi_next;
  logic             ge;

  assign rem_shift = {rem, acc[SUM_W-1]};

  // operand selection for the shared adder
  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    case (phase)
      U_DIFF: begin
        opa = {{(ACC_W-SAMPLE_W){x[SAMPLE_W-1]}}, x};
        opb = {{(ACC_W-SAMPLE_W){prev[SAMPLE_W-1]}}, prev};
        sub = 1'b1;
      end
      U_MUL: begin
        opa = {{(ACC_W-HI_W){acc[ACC_W-1]}}, acc[ACC_W-1:ALPHA_W]};
        opb = {{(ACC_W-DIFF_W){dval[DIFF_W-1]}}, dval};
      end
      U_RND: begin
        opa = acc;
        opb = ACC_W'(1) << (FRAC_W - 1);
      end
      U_ADDP: begin
        opa = {{FRAC_W{acc[ACC_W-1]}}, acc[ACC_W-1:FRAC_W]};
        opb = {{(ACC_W-SAMPLE_W){prev[SAMPLE_W-1]}}, prev};
      end
      U_ABS: begin
        opb = {{(ACC_W-SUM_W){sum_in[SUM_W-1]}}, sum_in};
        sub = sum_in[SUM_W-1];
      end
      U_DIV: begin
        opa = {{(ACC_W-17){1'b0}}, rem_shift};
        opb = {{(ACC_W-16){1'b0}}, divisor};
        sub = 1'b1;
      end
      U_RCMP: begin
        opa = {{(ACC_W-17){1'b0}}, rem, 1'b0};
        opb = {{(ACC_W-16){1'b0}}, divisor};
        sub = 1'b1;
      end
      U_RINC: begin
        opa = acc;
        opb = {{(ACC_W-1){1'b0}}, rnd};
      end
      U_SIGN: begin
        opb = acc;
        sub = neg;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  // the one adder/subtractor
  assign sum_w   = opa + (sub ? ~opb : opb) + {{(ACC_W-1){1'b0}}, sub};
  assign ge      = ~sum_w[ACC_W-1];
  assign hi_next = acc[0] ? sum_w[HI_W-1:0] : acc[ACC_W-1:ALPHA_W];

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= U_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= (phase == U_ADDP) || (phase == U_SIGN);
      case (phase)
        U_IDLE: begin
          if (cmd.start) begin
            phase <= cmd.seed ? U_ABS : U_DIFF;
          end
        end
        U_DIFF: begin
          dval  <= sum_w[DIFF_W-1:0];
          acc   <= {{HI_W{1'b0}}, alpha};
          step  <= '0;
          phase <= U_MUL;
        end
        // shift-add multiply, one multiplier bit per cycle
        U_MUL: begin
          acc  <= {hi_next[HI_W-1], hi_next, acc[ALPHA_W-1:1]};
          step <= step + 1'b1;
          if (step == STEP_W'(MUL_STEPS - 1)) begin
            phase <= U_RND;
          end
        end
        U_RND: begin
          acc   <= sum_w;
          phase <= U_ADDP;
        end
        U_ADDP: begin
          result <= sum_w[SAMPLE_W-1:0];
          phase  <= U_IDLE;
        end
        U_ABS: begin
          neg   <= sum_in[SUM_W-1];
          acc   <= sum_w;
          rem   <= '0;
          step  <= '0;
          phase <= U_DIV;
        end
        // restoring divide, one quotient bit per cycle
        U_DIV: begin
          rem          <= ge ? sum_w[15:0] : rem_shift[15:0];
          acc[SUM_W-1:0] <= {acc[SUM_W-2:0], ge};
          step         <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            phase <= U_RCMP;
          end
        end
        U_RCMP: begin
          rnd   <= ge;
          phase <= U_RINC;
        end
        U_RINC: begin
          acc   <= sum_w;
          phase <= U_SIGN;
        end
        U_SIGN: begin
          result <= sum_w[SAMPLE_W-1:0];
          phase  <= U_IDLE;
        end
        default: begin
          phase <= U_IDLE;
        end
      endcase
    end
  end

  assign stat.busy = (phase != U_IDLE);
  assign stat.done = done;

  // a command only arrives while the unit is free
  assert property (@(posedge clk) disable iff (rst) cmd.start |-> phase == U_IDLE)
    else $error("ess_unit: start while busy");
  // done pulses exactly once after the last step
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(phase) == U_ADDP || $past(phase) == U_SIGN))
    else $error("ess_unit: done without final step");
  // a start always leaves idle on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (phase == U_IDLE && cmd.start) |=> (phase == U_DIFF || phase == U_ABS))
    else $error("ess_unit: start not taken");

endmodule

/* rtl/core/ema_sma_seeded.sv */
// top level: config registers, series bookkeeping, sequencer and output register
//
// Streaming moving average with a simple-average seed, signed Q16.16.
// Input channel s_axis_*: tdata carries the sample, tuser the series start flag.
// Output channel m_axis_*: tdata carries the average, tuser the valid flag;
// one result item leaves for every input item, in order.
// Config port cfg_*: index 0 is the window length, index 1 is alpha (Q1.16,
// values above 1.0 act as 1.0); write only while no item is in flight.
// Timing: the block takes one item at a time; s_axis_tready drops after an
// accept that starts the unit or finds the output blocked. Items before the seed
// finish in the accept cycle. An ema update runs in the shared adder around a
// bit-serial multiply by alpha; a seed runs around a bit-serial divide by the
// window. If the output is free, the result shows on m_axis the cycle after the
// unit finishes, and the next item is accepted from that cycle on.
// The output register lets one result wait while the next item is worked on;
// when the receiver stalls longer, the block holds the finished result and
// keeps s_axis_tready low until it can be passed on.
// Reset (rst, synchronous) empties the output, clears the count, sum and
// previous average, and sets window 1, alpha 1.0.
module ema_sma_seeded import ess_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // input item
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // [31:0] sample
  input  logic                s_axis_tuser,   // [0] series_start
  // result item
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // [31:0] average
  output logic                m_axis_tuser,   // [0] average_valid
  // configuration writes
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BUSY = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]                 state;
  logic [15:0]                window_length;
  logic [ALPHA_W-1:0]         smoothing_factor;
  logic [COUNT_W-1:0]         sample_count;
  logic signed [SUM_W-1:0]    running_sum;
  logic signed [SAMPLE_W-1:0] previous_average;
  logic signed [SAMPLE_W-1:0] x_reg;

  logic                       out_full;
  logic [SAMPLE_W-1:0]        out_avg;
  logic                       out_vld;
  logic [SAMPLE_W-1:0]        pend_avg;
  logic                       pend_vld;

  logic                       accept;
  logic                       out_free;
  logic                       out_load;
  logic [COUNT_W-1:0]         cnt0;
  logic                       counted;
  logic [COUNT_W-1:0]         n_next;
  logic                       win_zero;
  logic                       add_sum;
  logic                       do_seed;
  logic                       do_ema;
  logic signed [SUM_W-1:0]    sum0;
  logic signed [SUM_W-1:0]    sum_next;
  logic [ALPHA_W-1:0]         alpha_eff;

  ess_cmd_t                   ucmd;
  ess_stat_t                  ustat;
  logic signed [SAMPLE_W-1:0] uresult;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !out_full || m_axis_tready;
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = out_avg;
  assign m_axis_tuser  = out_vld;

  // a new result enters the output register this cycle
  assign out_load = out_free && ((accept && !(do_seed || do_ema))
                              || ((state == S_BUSY) && ustat.done)
                              || (state == S_HOLD));

  assign alpha_eff = (smoothing_factor > ALPHA_ONE) ? ALPHA_ONE : smoothing_factor;

  // series bookkeeping for the item at the input
  always_comb begin
    cnt0     = s_axis_tuser ? '0 : sample_count;
    counted  = (cnt0 != COUNT_MAX);
    n_next   = counted ? cnt0 + 1'b1 : COUNT_MAX;
    win_zero = (window_length == '0);
    add_sum  = counted && (win_zero || (16'(n_next) <= window_length));
    do_seed  = counted && !win_zero && (16'(n_next) == window_length);
    do_ema   = !win_zero && (16'(n_next) > window_length);
    sum0     = s_axis_tuser ? '0 : running_sum;
    sum_next = add_sum
             ? sum0 + {{(SUM_W-SAMPLE_W){s_axis_tdata[SAMPLE_W-1]}}, s_axis_tdata}
             : sum0;
  end

  assign ucmd.start = accept && (do_seed || do_ema);
  assign ucmd.seed  = do_seed;

  ess_unit u_unit (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ucmd),
    .stat    (ustat),
    .x       (x_reg),
    .prev    (previous_average),
    .alpha   (alpha_eff),
    .sum_in  (running_sum),
    .divisor (window_length),
    .result  (uresult)
  );

  // config, sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      window_length    <= WINDOW_INIT;
      smoothing_factor <= ALPHA_ONE;
      sample_count     <= '0;
      running_sum      <= '0;
      previous_average <= '0;
      out_full         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW: window_length    <= cfg_data[15:0];
          REG_ALPHA:  smoothing_factor <= cfg_data[ALPHA_W-1:0];
          default:    window_length    <= window_length;
        endcase
      end

      if (out_full && m_axis_tready && !out_load) begin
        out_full <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            x_reg        <= s_axis_tdata;
            sample_count <= n_next;
            running_sum  <= sum_next;
            if (do_seed || do_ema) begin
              state <= S_BUSY;
            end else if (out_free) begin
              out_full <= 1'b1;
              out_avg  <= '0;
              out_vld  <= 1'b0;
            end else begin
              pend_avg <= '0;
              pend_vld <= 1'b0;
              state    <= S_HOLD;
            end
          end
        end
        S_BUSY: begin
          if (ustat.done) begin
            previous_average <= uresult;
            if (out_free) begin
              out_full <= 1'b1;
              out_avg  <= uresult;
              out_vld  <= 1'b1;
              state    <= S_IDLE;
            end else begin
              pend_avg <= uresult;
              pend_vld <= 1'b1;
              state    <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_full <= 1'b1;
            out_avg  <= pend_avg;
            out_vld  <= pend_vld;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a not-valid result always carries a zero average
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("ema_sma_seeded: invalid result with nonzero data");
  // the unit only runs or finishes while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst)
    (ustat.busy || ustat.done) |-> (state == S_BUSY))
    else $error("ema_sma_seeded: unit active outside busy state");
  // the count steps by one for an item that continues an unsaturated series
  assert property (@(posedge clk) disable iff (rst)
    (accept && !s_axis_tuser && (sample_count != COUNT_MAX))
      |=> (sample_count == $past(sample_count) + 1'b1))
    else $error("ema_sma_seeded: sample count did not advance");
  // a series start leaves a count of one
  assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tuser) |=> (sample_count == COUNT_W'(1)))
    else $error("ema_sma_seeded: series start did not restart count");

endmodule

/* verif/tb_ema_sma_seeded.sv */
// testbench for ema_sma_seeded: directed table and random phases
module tb_ema_sma_seeded import ess_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int N_DIR = 35;
  localparam longint S_MAX = 64'sh7FFF_FFFF;
  localparam longint S_MIN = -64'sh8000_0000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       valid;
  } avg_item_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_KNOWN, ROW_CFG} row_kind_t;

  // one directed step: a register write, or an item with an optional typed-in result
  typedef struct packed {
    row_kind_t             kind;
    logic [IDX_W-1:0]      reg_idx;
    logic [CFG_W-1:0]      reg_val;
    logic [SAMPLE_W-1:0]   sample;
    logic                  start;
    logic [SAMPLE_W-1:0]   avg;
    logic                  avg_ok;
  } stim_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;   // [31:0] sample
  logic                s_axis_tuser = 1'b0; // [0] series_start
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;        // [31:0] average
  logic                m_axis_tuser;        // [0] average_valid
  logic                cfg_we = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;

  // predictor copy of the registers and the series state
  logic [15:0]                win_len = WINDOW_INIT;
  logic [ALPHA_W-1:0]         alpha_q16 = ALPHA_ONE;
  logic [COUNT_W-1:0]         seen_count = '0;
  longint                     series_sum = 0;
  logic signed [SAMPLE_W-1:0] last_avg = '0;

  avg_item_t avgs_due [$];

  stim_row_t directed_rows [N_DIR] = '{
    // window 1 after reset: the first sample is its own seed, then alpha 1.0 passes samples
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'h8000_0000, 1'b0, 32'h8000_0000, 1'b1},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1},
    // window 3, alpha one half
    '{ROW_CFG,   REG_WINDOW, 17'd3, 32'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,   REG_ALPHA,  17'd32768, 32'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'h0001_0000, 1'b1, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'h0002_0000, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,  REG_WINDOW, 17'd0, 32'h0003_0001, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,  REG_WINDOW, 17'd0, 32'h7FFF_FFFF, 1'b0, 32'd0, 1'b0},
    // window shrunk below the count mid-series
    '{ROW_CFG,   REG_WINDOW, 17'd2, 32'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,  REG_WINDOW, 17'd0, 32'h8000_0000, 1'b0, 32'd0, 1'b0},
    // window zero never gives a valid result
    '{ROW_CFG,   REG_WINDOW, 17'd0, 32'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'h5555_5555, 1'b1, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'hAAAA_AAAA, 1'b0, 32'd0, 1'b0},
    // negative tie in the seed rounds away from zero: -3/2 gives -2
    '{ROW_CFG,   REG_WINDOW, 17'd2, 32'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'hFFFF_FFFE, 1'b0, 32'hFFFF_FFFE, 1'b1},
    // alpha zero holds the previous average
    '{ROW_CFG,   REG_ALPHA,  17'd0, 32'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'h1234_5678, 1'b0, 32'hFFFF_FFFE, 1'b1},
    // alpha above one acts as one
    '{ROW_CFG,   REG_ALPHA,  17'h1_FFFF, 32'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'h5A5A_5A5A, 1'b0, 32'h5A5A_5A5A, 1'b1},
    // top bit of the window write is dropped, 2/3 rounds up to 1
    '{ROW_CFG,   REG_WINDOW, 17'h1_0003, 32'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'd1, 1'b1, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'd1, 1'b0, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'd0, 1'b0, 32'd1, 1'b1},
    // window lowered to count+1 gives a fresh seed from the running sum
    '{ROW_CFG,   REG_WINDOW, 17'd10, 32'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'd6, 1'b1, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'd9, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,   REG_WINDOW, 17'd3, 32'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'd0, 1'b0, 32'd5, 1'b1},
    // positive tie rounds up: 3/2 gives 2, then a typical alpha
    '{ROW_CFG,   REG_ALPHA,  17'd21845, 32'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG,   REG_WINDOW, 17'd2, 32'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'd1, 1'b1, 32'd0, 1'b0},
    '{ROW_KNOWN, REG_WINDOW, 17'd0, 32'd2, 1'b0, 32'd2, 1'b1},
    '{ROW_ITEM,  REG_WINDOW, 17'd0, 32'hC000_0000, 1'b0, 32'd0, 1'b0}
  };

  ema_sma_seeded i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // saturate to the signed sample range
  function automatic logic signed [SAMPLE_W-1:0] clamp_q16(longint v);
    if (v > S_MAX) return S_MAX[SAMPLE_W-1:0];
    if (v < S_MIN) return S_MIN[SAMPLE_W-1:0];
    return v[SAMPLE_W-1:0];
  endfunction

  // seed: sum / n, ties away from zero
  function automatic logic signed [SAMPLE_W-1:0] seed_average(longint total, logic [15:0] n);
    longint unsigned mag, q, r;
    mag = (total < 0) ? -total : total;
    q = mag / n;
    r = mag % n;
    if (r * 2 >= n) q = q + 1;
    return clamp_q16((total < 0) ? -longint'(q) : longint'(q));
  endfunction

  // ema: floor((a*x + (1-a)*p + half) / one), exact in 64 bits
  function automatic logic signed [SAMPLE_W-1:0] blend_average(logic signed [SAMPLE_W-1:0] x,
                                                               logic signed [SAMPLE_W-1:0] p,
                                                               logic [ALPHA_W-1:0] a);
    logic [ALPHA_W-1:0] b;
    longint acc;
    b = ALPHA_ONE - a;
    acc = longint'(a) * longint'(x) + longint'(b) * longint'(p) + 64'sd32768;
    return clamp_q16(acc >>> 16);
  endfunction

  // advance the series state by one item and return its result
  function automatic avg_item_t predict_average(logic signed [SAMPLE_W-1:0] x, logic start);
    logic [COUNT_W-1:0] n;
    logic counted;
    logic [ALPHA_W-1:0] a;
    avg_item_t res;
    res = '0;
    a = (alpha_q16 > ALPHA_ONE) ? ALPHA_ONE : alpha_q16;
    if (start) begin
      seen_count = '0;
      series_sum = 0;
    end
    counted = (seen_count != COUNT_MAX);
    n = counted ? seen_count + 1'b1 : COUNT_MAX;
    seen_count = n;
    if (win_len == 0) begin
      if (counted) series_sum += longint'(x);
    end else if (counted && n < win_len) begin
      series_sum += longint'(x);
    end else if (counted && n == win_len) begin
      series_sum += longint'(x);
      res.average = seed_average(series_sum, win_len);
      res.valid = 1'b1;
      last_avg = res.average;
    end else if (n > win_len) begin
      res.average = blend_average(x, last_avg, a);
      res.valid = 1'b1;
      last_avg = res.average;
    end
    return res;
  endfunction

  // software setting for alpha: round(2/(w+1)) in Q1.16, kept within the register
  function automatic logic [ALPHA_W-1:0] alpha_for(logic [15:0] w);
    int d, v;
    d = int'(w) + 1;
    v = (131072 + d / 2) / d;
    return (v > 131071) ? 17'h1_FFFF : ALPHA_W'(v);
  endfunction

  // mix of full-range, small, extreme and tiny fractional samples
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom;
    if (r < 75) return 32'($urandom_range(0, 262143)) - 32'd131072;
    if (r < 90) begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'hFFFF_FFFF;
        default: return 32'd0;
      endcase
    end
    return 32'($urandom_range(0, 255));
  endfunction

  // offer one item, with random gaps, and queue its result once accepted
  task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic start,
                           input logic use_known, input avg_item_t known);
    avg_item_t due;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    due = predict_average($signed(smp), start);
    if (use_known) due = known;
    avgs_due.push_back(due);
  endtask

  // stop sending and wait for every queued result
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (avgs_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_WINDOW) win_len = val[15:0];
    else alpha_q16 = val[ALPHA_W-1:0];
  endtask

  // segments of random items, with new settings between them
  task automatic run_random_phase(input int items_left);
    int seg, r, k;
    logic [15:0] w;
    logic [ALPHA_W-1:0] a;
    logic fresh;
    while (items_left > 0) begin
      drain();
      r = $urandom_range(99);
      if (r < 8) w = 16'd0;
      else if (r < 16) w = 16'd1;
      else if (r < 70) w = 16'($urandom_range(2, 8));
      else if (r < 90) w = 16'($urandom_range(9, 40));
      else w = 16'($urandom_range(41, 120));
      if ($urandom_range(9) != 0) write_reg(REG_WINDOW, {1'($urandom_range(1)), w});
      r = $urandom_range(99);
      if (r < 80) a = alpha_for(win_len);
      else if (r < 90) a = ALPHA_W'($urandom_range(17'h1_FFFF));
      else if (r < 94) a = '0;
      else if (r < 97) a = ALPHA_ONE;
      else a = 17'h1_FFFF;
      if ($urandom_range(9) != 0) write_reg(REG_ALPHA, a);
      seg = $urandom_range(10, 40);
      if (seg > items_left) seg = items_left;
      fresh = ($urandom_range(9) < 6);
      for (k = 0; k < seg; k++)
        send_item(pick_sample(), (k == 0 && fresh) || ($urandom_range(24) == 0), 1'b0, '0);
      items_left -= seg;
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    // keep the log short on a broken design
    if (mismatches <= 100)
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  // receiver stalls
  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  // compare each result item with the oldest expectation
  always @(posedge clk) begin : check_avg
    avg_item_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (avgs_due.size() == 0) begin
        note_mismatch("unexpected result", 32'd0, m_axis_tdata);
      end else begin
        want = avgs_due.pop_front();
        if (m_axis_tdata !== want.average) note_mismatch("average", want.average, m_axis_tdata);
        if (m_axis_tuser !== want.valid) note_mismatch("average_valid", want.valid, m_axis_tuser);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin : watchdog
    int quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int i;
    stim_row_t row;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    send_idle_pct = 18;
    recv_idle_pct = 49;
    for (i = 0; i < N_DIR; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        drain();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.sample, row.start, row.kind == ROW_KNOWN,
                  avg_item_t'{row.avg, row.avg_ok});
      end
    end

    // random items under three idling patterns
    run_random_phase(150);
    send_idle_pct = 49;
    recv_idle_pct = 18;
    run_random_phase(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(150);

    drain();
    repeat (60) @(posedge clk);
    if (avgs_due.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, avgs_due.size());
    end
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
